FILE: rtl/core/bfc_pkg.sv
package bfc_pkg;

    localparam int NumPlanes = 6;
    localparam int NumAxes   = 3;
    localparam int CoordW    = 16;   // input coordinate width
    localparam int ShiftW    = 17;   // corner plus offset, exact
    localparam int CoefW     = 16;   // a, b, c in Q1.14, d integer
    localparam int ProdW     = CoefW + ShiftW;
    localparam int SumW      = 35;   // three products plus scaled d
    localparam int FracBits  = 14;
    localparam int PlaneW    = 4 * CoefW;
    localparam int CfgIdxW   = 3;
    localparam int InDataW   = 3 * NumAxes * CoordW;
    localparam int OutDataW  = 8;

    typedef logic [PlaneW-1:0]        plane_t;
    typedef plane_t                   plane_arr_t [NumPlanes];
    typedef logic signed [CoordW-1:0] coord_t;
    typedef coord_t                   coord_vec_t [NumAxes];
    typedef logic signed [ShiftW-1:0] shift_t;
    typedef shift_t                   shift_vec_t [NumAxes];
    typedef logic signed [CoefW-1:0]  coef_t;
    typedef logic signed [ProdW-1:0]  prod_t;
    typedef logic signed [SumW-1:0]   sum_t;

    typedef enum logic [1:0] {
        VIS_OUTSIDE   = 2'd0,
        VIS_INTERSECT = 2'd1,
        VIS_INSIDE    = 2'd2
    } vis_t;

    // load enables for the stages held inside the plane units
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } stage_en_t;

    typedef struct packed {
        logic any_front;   // at least one corner strictly in front
        logic all_front;   // all eight corners strictly in front
    } plane_flags_t;

    // coefficient k of a plane word: 0 = a, 1 = b, 2 = c, 3 = d
    function automatic coef_t plane_coef(input plane_t p, input int k);
        return coef_t'(p[(NumAxes - k) * CoefW +: CoefW]);
    endfunction

endpackage

FILE: rtl/core/box_frustum_classifier.sv
// Box against view frustum classifier.
// s_ channel: one word per box. s_tuser carries has_box; a word with
// has_box low skips the test and reports intersecting.
// m_ channel: one word per input word, in order; m_tdata[1:0] is the
// visibility code (0 outside, 1 intersecting, 2 fully inside).
// cfg_ channel: writes plane register cfg_index (0 right, 1 left,
// 2 bottom, 3 top, 4 far, 5 near); other indexes are ignored. Always ready.
// Write planes only while no word is in flight.
// Each word passes through the input, bounds, product, sum and output
// registers in that order.
// Throughput: one word per clock while m_tready is high. Every stage has its
// own valid bit and loads whenever the stage after it is empty or moving, so
// bubbles close up when m_tready is low and s_tready drops only once every
// stage holds a word. Each plane has its own six 16x17 multipliers.
// Reset: all stages empty, all plane registers zero (every box then
// classifies as outside).
module box_frustum_classifier (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, offset_x, offset_y, offset_z
    input  logic [bfc_pkg::InDataW-1:0]          s_tdata,
    // has_box
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // visibility, zero padded
    output logic [bfc_pkg::OutDataW-1:0]         m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bfc_pkg::CfgIdxW-1:0]          cfg_index,
    input  logic [bfc_pkg::PlaneW-1:0]           cfg_data
);

    localparam int W = bfc_pkg::CoordW;
    localparam int A = bfc_pkg::NumAxes;

    bfc_pkg::plane_arr_t   planes;
    bfc_pkg::plane_flags_t flags [bfc_pkg::NumPlanes];
    bfc_pkg::stage_en_t    plane_en;

    // stage valids
    logic in_valid_reg, bnd_valid_reg, prod_valid_reg, sum_valid_reg, m_tvalid_reg;
    logic in_box_reg, bnd_box_reg, prod_box_reg, sum_box_reg;
    logic in_en, bnd_en, prod_en, sum_en, out_en;

    bfc_pkg::coord_vec_t in_min_reg, in_max_reg, in_off_reg;
    bfc_pkg::shift_vec_t bnd_lo_reg, bnd_hi_reg, bnd_lo_next, bnd_hi_next;
    bfc_pkg::vis_t       vis_reg, vis_next;

    assign out_en   = !m_tvalid_reg || m_tready;
    assign sum_en   = !sum_valid_reg || out_en;
    assign prod_en  = !prod_valid_reg || sum_en;
    assign bnd_en   = !bnd_valid_reg || prod_en;
    assign in_en    = !in_valid_reg || bnd_en;
    assign s_tready = in_en;

    assign plane_en.prod_en = prod_en;
    assign plane_en.sum_en  = sum_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            bnd_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (in_en)   in_valid_reg   <= s_tvalid;
            if (bnd_en)  bnd_valid_reg  <= in_valid_reg;
            if (prod_en) prod_valid_reg <= bnd_valid_reg;
            if (sum_en)  sum_valid_reg  <= prod_valid_reg;
            if (out_en)  m_tvalid_reg   <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en) begin
            in_box_reg <= s_tuser;
            for (int ax = 0; ax < A; ax++) begin
                in_min_reg[ax] <= s_tdata[ax * W +: W];
                in_max_reg[ax] <= s_tdata[(A + ax) * W +: W];
                in_off_reg[ax] <= s_tdata[(2 * A + ax) * W +: W];
            end
        end
    end

    // shift both corners, then order each axis so lo <= hi
    always_comb begin
        bfc_pkg::shift_t a0;
        bfc_pkg::shift_t a1;
        for (int ax = 0; ax < A; ax++) begin
            a0 = bfc_pkg::shift_t'(in_min_reg[ax]) + bfc_pkg::shift_t'(in_off_reg[ax]);
            a1 = bfc_pkg::shift_t'(in_max_reg[ax]) + bfc_pkg::shift_t'(in_off_reg[ax]);
            bnd_lo_next[ax] = (a0 > a1) ? a1 : a0;
            bnd_hi_next[ax] = (a0 > a1) ? a0 : a1;
        end
    end

    always_ff @(posedge aclk) begin
        if (bnd_en) begin
            bnd_box_reg <= in_box_reg;
            bnd_lo_reg  <= bnd_lo_next;
            bnd_hi_reg  <= bnd_hi_next;
        end
        if (prod_en) prod_box_reg <= bnd_box_reg;
        if (sum_en)  sum_box_reg  <= prod_box_reg;
    end

    bfc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    for (genvar p = 0; p < bfc_pkg::NumPlanes; p++) begin : g_plane
        bfc_plane_eval u_eval (
            .aclk  (aclk),
            .en    (plane_en),
            .plane (planes[p]),
            .lo    (bnd_lo_reg),
            .hi    (bnd_hi_reg),
            .flags (flags[p])
        );
    end

    always_comb begin
        logic any_out;
        logic all_in;
        any_out = 1'b0;
        all_in  = 1'b1;
        for (int p = 0; p < bfc_pkg::NumPlanes; p++) begin
            any_out = any_out || !flags[p].any_front;
            all_in  = all_in && flags[p].all_front;
        end
        if (!sum_box_reg) begin
            vis_next = bfc_pkg::VIS_INTERSECT;
        end else if (any_out) begin
            vis_next = bfc_pkg::VIS_OUTSIDE;
        end else if (all_in) begin
            vis_next = bfc_pkg::VIS_INSIDE;
        end else begin
            vis_next = bfc_pkg::VIS_INTERSECT;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            vis_reg <= vis_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = bfc_pkg::OutDataW'(vis_reg);

endmodule

FILE: rtl/core/bfc_cfg_regs.sv
module bfc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bfc_pkg::PlaneW-1:0]    cfg_data,
    output bfc_pkg::plane_arr_t           planes
);

    bfc_pkg::plane_arr_t planes_reg;
    bfc_pkg::plane_arr_t planes_next;

    assign cfg_ready = 1'b1;

    // indexes past the last plane are dropped
    always_comb begin
        planes_next = planes_reg;
        for (int i = 0; i < bfc_pkg::NumPlanes; i++) begin
            if (cfg_valid && cfg_index == bfc_pkg::CfgIdxW'(i)) begin
                planes_next[i] = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bfc_pkg::NumPlanes; i++) begin
                planes_reg[i] <= '0;
            end
        end else begin
            planes_reg <= planes_next;
        end
    end

    assign planes = planes_reg;

endmodule

FILE: rtl/core/bfc_plane_eval.sv
module bfc_plane_eval (
    input  logic                   aclk,
    input  bfc_pkg::stage_en_t     en,
    input  bfc_pkg::plane_t        plane,
    input  bfc_pkg::shift_vec_t    lo,     // per-axis minimum, already ordered
    input  bfc_pkg::shift_vec_t    hi,     // per-axis maximum
    output bfc_pkg::plane_flags_t  flags
);

    // The dot product is separable per axis, so the best and worst corners
    // come from picking lo or hi by the sign of each coefficient.
    bfc_pkg::prod_t        pmax_reg  [bfc_pkg::NumAxes];
    bfc_pkg::prod_t        pmin_reg  [bfc_pkg::NumAxes];
    bfc_pkg::prod_t        pmax_next [bfc_pkg::NumAxes];
    bfc_pkg::prod_t        pmin_next [bfc_pkg::NumAxes];
    bfc_pkg::plane_flags_t flags_reg;
    bfc_pkg::plane_flags_t flags_next;

    always_comb begin
        bfc_pkg::coef_t  coef;
        bfc_pkg::shift_t op_max;
        bfc_pkg::shift_t op_min;
        for (int ax = 0; ax < bfc_pkg::NumAxes; ax++) begin
            coef   = bfc_pkg::plane_coef(plane, ax);
            op_max = coef[bfc_pkg::CoefW-1] ? lo[ax] : hi[ax];
            op_min = coef[bfc_pkg::CoefW-1] ? hi[ax] : lo[ax];
            pmax_next[ax] = coef * op_max;
            pmin_next[ax] = coef * op_min;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.prod_en) begin
            pmax_reg <= pmax_next;
            pmin_reg <= pmin_next;
        end
    end

    always_comb begin
        bfc_pkg::sum_t d_scaled;
        bfc_pkg::sum_t smax;
        bfc_pkg::sum_t smin;
        d_scaled = bfc_pkg::sum_t'(bfc_pkg::plane_coef(plane, bfc_pkg::NumAxes))
                   <<< bfc_pkg::FracBits;
        smax = bfc_pkg::sum_t'(pmax_reg[0]) + bfc_pkg::sum_t'(pmax_reg[1])
             + bfc_pkg::sum_t'(pmax_reg[2]) + d_scaled;
        smin = bfc_pkg::sum_t'(pmin_reg[0]) + bfc_pkg::sum_t'(pmin_reg[1])
             + bfc_pkg::sum_t'(pmin_reg[2]) + d_scaled;
        flags_next.any_front = !smax[bfc_pkg::SumW-1] && (smax != '0);
        flags_next.all_front = !smin[bfc_pkg::SumW-1] && (smin != '0);
    end

    always_ff @(posedge aclk) begin
        if (en.sum_en) begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

FILE: tb/sv/box_visibility_checker.sv
`timescale 1ns / 100ps

module box_visibility_checker
    import bfc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OutDataW-1:0] m_tdata,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  plane_t              cfg_data,
    output int                  fail_count,
    output int                  pending_words,
    output int                  n_outside,
    output int                  n_intersect,
    output int                  n_inside
);

    localparam int Corners = 8;

    plane_t frustum_planes [NumPlanes];
    vis_t   vis_expected [$];

    // corner k takes the high bound on axis j when bit j of k is set
    function automatic vis_t classify_box(input logic has_box, input logic [InDataW-1:0] word);
        longint lo [NumAxes];
        longint hi [NumAxes];
        longint off, px, py, pz, acc;
        longint ca, cb, cc, cd;
        int     front;
        int     full;
        if (!has_box)
            return VIS_INTERSECT;
        for (int ax = 0; ax < NumAxes; ax++) begin
            off    = longint'($signed(word[(2*NumAxes + ax)*CoordW +: CoordW]));
            lo[ax] = longint'($signed(word[ax*CoordW +: CoordW])) + off;
            hi[ax] = longint'($signed(word[(NumAxes + ax)*CoordW +: CoordW])) + off;
        end
        full = 0;
        for (int p = 0; p < NumPlanes; p++) begin
            ca = longint'($signed(frustum_planes[p][63:48]));
            cb = longint'($signed(frustum_planes[p][47:32]));
            cc = longint'($signed(frustum_planes[p][31:16]));
            cd = longint'($signed(frustum_planes[p][15:0]));
            front = 0;
            for (int k = 0; k < Corners; k++) begin
                px  = (k & 1) ? hi[0] : lo[0];
                py  = (k & 2) ? hi[1] : lo[1];
                pz  = (k & 4) ? hi[2] : lo[2];
                acc = ca * px + cb * py + cc * pz + cd * (longint'(1) << FracBits);
                if (acc > 0)
                    front++;
            end
            if (front == 0)
                return VIS_OUTSIDE;
            if (front == Corners)
                full++;
        end
        return (full == NumPlanes) ? VIS_INSIDE : VIS_INTERSECT;
    endfunction

    task automatic flag_error(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge aclk) begin
        vis_t want;
        if (!aresetn) begin
            foreach (frustum_planes[i])
                frustum_planes[i] = '0;
            vis_expected.delete();
        end else begin
            if (cfg_valid && cfg_ready && cfg_index < NumPlanes)
                frustum_planes[cfg_index] = cfg_data;
            if (s_tvalid && s_tready)
                vis_expected.push_back(classify_box(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (vis_expected.size() == 0) begin
                    flag_error("unexpected word", -1, int'(m_tdata[1:0]));
                end else begin
                    want = vis_expected.pop_front();
                    if (m_tdata[1:0] != want)
                        flag_error("visibility", int'(want), int'(m_tdata[1:0]));
                    case (want)
                        VIS_OUTSIDE:   n_outside++;
                        VIS_INTERSECT: n_intersect++;
                        default:       n_inside++;
                    endcase
                end
            end
        end
        pending_words <= vis_expected.size();
    end

endmodule

FILE: tb/sv/tb_box_frustum_classifier.sv
`timescale 1ns / 100ps

module tb_box_frustum_classifier;
    import bfc_pkg::*;

    localparam int One        = 1 << FracBits;
    localparam int Diag       = 11585;   // 1/sqrt(2) in Q1.14
    localparam int PhaseItems = 195;
    localparam int HoldCycles = 200;
    localparam int IdlePct    = 21;

    typedef enum logic [CfgIdxW-1:0] {
        REG_RIGHT, REG_LEFT, REG_BOTTOM, REG_TOP, REG_FAR, REG_NEAR, REG_SPARE_A, REG_SPARE_B
    } reg_idx_t;

    // last member sits in the lowest bits
    typedef struct packed {
        coord_t off_z, off_y, off_x;
        coord_t max_z, max_y, max_x;
        coord_t min_z, min_y, min_x;
    } box_word_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    plane_t              cfg_data  = '0;

    logic hold_req = 1'b0;
    logic no_idle  = 1'b0;
    int   plane_sets = 0;
    int   fail_count, pending_words, n_outside, n_intersect, n_inside;

    always #5 aclk = ~aclk;

    box_frustum_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    box_visibility_checker vis_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .n_outside     (n_outside),
        .n_intersect   (n_intersect),
        .n_inside      (n_inside)
    );

    initial begin
        #2_000_000;
        $display("Timed out with %0d words still expected", pending_words);
        $display("RESULT: ERROR");
        $finish;
    end

    // output side: random stalls, one long hold-off on request
    initial begin : receiver
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end
            m_tready <= no_idle || ($urandom_range(99) >= IdlePct);
        end
    end

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic coord_t to_coord(input int v);
        if (v > 32767)
            return coord_t'(32767);
        if (v < -32768)
            return coord_t'(-32768);
        return coord_t'(v);
    endfunction

    function automatic plane_t mk_plane(input int a, input int b, input int c, input int d);
        return {coef_t'(a), coef_t'(b), coef_t'(c), coef_t'(d)};
    endfunction

    function automatic box_word_t noise_box();
        box_word_t w;
        for (int k = 0; k < 3 * NumAxes; k++)
            w[k*CoordW +: CoordW] = CoordW'($urandom_range(16'hFFFF));
        return w;
    endfunction

    function automatic box_word_t cube_box(input int lo, input int hi,
                                           input int ox, input int oy, input int oz);
        box_word_t w;
        w.min_x = coord_t'(lo);
        w.min_y = coord_t'(lo);
        w.min_z = coord_t'(lo);
        w.max_x = coord_t'(hi);
        w.max_y = coord_t'(hi);
        w.max_z = coord_t'(hi);
        w.off_x = coord_t'(ox);
        w.off_y = coord_t'(oy);
        w.off_z = coord_t'(oz);
        return w;
    endfunction

    // box near the frustum scale; offset is folded out so the shifted box lands there
    function automatic void shape_axis(input int span, output coord_t mn, output coord_t mx,
                                       output coord_t off);
        int ctr, hs, o;
        o   = rand_between(-4000, 4000);
        ctr = rand_between(-2 * span, 2 * span);
        hs  = ($urandom_range(3) == 0) ? rand_between(0, 3) : rand_between(0, span);
        mn  = to_coord(ctr - hs - o);
        mx  = to_coord(ctr + hs - o);
        off = coord_t'(o);
        if ($urandom_range(19) == 0) begin
            mn = to_coord(ctr + hs - o);
            mx = to_coord(ctr - hs - o);
        end
    endfunction

    function automatic box_word_t shaped_box(input int span);
        box_word_t w;
        shape_axis(span, w.min_x, w.max_x, w.off_x);
        shape_axis(span, w.min_y, w.max_y, w.off_y);
        shape_axis(span, w.min_z, w.max_z, w.off_z);
        return w;
    endfunction

    task automatic push_box(input logic has_box, input box_word_t w);
        s_tvalid <= 1'b1;
        s_tuser  <= has_box;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_for(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input plane_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic write_planes(input plane_t r, input plane_t l, input plane_t b,
                                input plane_t t, input plane_t f, input plane_t n);
        write_reg(REG_RIGHT, r);
        write_reg(REG_LEFT, l);
        write_reg(REG_BOTTOM, b);
        write_reg(REG_TOP, t);
        write_reg(REG_FAR, f);
        write_reg(REG_NEAR, n);
        cfg_valid <= 1'b0;
        plane_sets++;
    endtask

    // |x|, |y|, |z| < w
    task automatic load_cube(input int w);
        write_planes(mk_plane(-One, 0, 0, w), mk_plane(One, 0, 0, w),
                     mk_plane(0, One, 0, w), mk_plane(0, -One, 0, w),
                     mk_plane(0, 0, -One, w), mk_plane(0, 0, One, w));
    endtask

    // 90 degree view along +z between near and far
    task automatic load_view(input int n, input int f);
        write_planes(mk_plane(-Diag, 0, Diag, 0), mk_plane(Diag, 0, Diag, 0),
                     mk_plane(0, Diag, Diag, 0), mk_plane(0, -Diag, Diag, 0),
                     mk_plane(0, 0, -One, f), mk_plane(0, 0, One, -n));
    endtask

    task automatic run_boxes(input int count, input int span, input int pause_at);
        int        pick;
        logic      hb;
        box_word_t w;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at)
                settle();
            pick = $urandom_range(99);
            hb   = 1'b1;
            if (pick < 10) begin
                hb = 1'b0;
                w  = noise_box();
            end else if (pick < 28) begin
                w = noise_box();
            end else begin
                w = shaped_box(span);
            end
            // a random run of idle cycles before each box, so about IdlePct of the cycles go idle
            if (!no_idle) begin
                while ($urandom_range(99) < IdlePct)
                    idle_for(1);
            end
            push_box(hb, w);
        end
    endtask

    initial begin
        box_word_t w;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // planes still at reset: everything with a box is outside
        push_box(1'b1, '0);
        push_box(1'b0, '1);
        push_box(1'b1, cube_box(-32768, 32767, 0, 0, 0));
        settle();

        // writes to unused indexes must leave the planes alone
        write_reg(REG_SPARE_A, plane_t'({$urandom, $urandom}));
        write_reg(REG_SPARE_B, plane_t'({$urandom, $urandom}));
        load_cube(1000);

        push_box(1'b0, '1);
        push_box(1'b0, '0);
        push_box(1'b1, '0);
        w = '0;
        w.min_x = coord_t'(1000);
        w.max_x = coord_t'(1000);
        push_box(1'b1, w);                    // on the right plane: not in front
        w.min_x = coord_t'(999);
        w.max_x = coord_t'(999);
        push_box(1'b1, w);
        push_box(1'b1, cube_box(-500, 500, 0, 0, 0));
        push_box(1'b1, cube_box(-1500, 1500, 0, 0, 0));
        push_box(1'b1, cube_box(2000, 3000, 0, 0, 0));
        push_box(1'b1, cube_box(500, -500, 0, 0, 0));       // swapped corners
        push_box(1'b1, cube_box(1500, -1500, 0, 0, 0));
        push_box(1'b1, cube_box(32767, 32767, 32767, 32767, 32767));
        push_box(1'b1, cube_box(-32768, -32768, -32768, -32768, -32768));
        push_box(1'b1, cube_box(-32768, 32767, 0, 0, 0));
        push_box(1'b1, cube_box(-32768, 32767, -32768, 32767, 0));
        push_box(1'b1, cube_box(32767, 32767, -32767, -32767, -32767));
        push_box(1'b1, cube_box(-32768, -32768, 32767, 32767, 32767));
        push_box(1'b1, cube_box(-999, 999, 0, 0, 0));
        settle();

        hold_req <= 1'b1;
        run_boxes(PhaseItems, 1000, -1);
        settle();

        load_cube(32767);
        run_boxes(PhaseItems, 20000, -1);
        settle();

        load_cube(0);
        run_boxes(PhaseItems, 50, -1);
        settle();

        load_view(16, 4000);
        run_boxes(PhaseItems, 2000, PhaseItems / 2);
        settle();

        load_view(1000, 30000);
        no_idle <= 1'b1;
        run_boxes(PhaseItems, 15000, -1);
        no_idle <= 1'b0;
        settle();

        // constant term alone: every corner in front of every plane
        write_planes(mk_plane(0, 0, 0, 32767), mk_plane(0, 0, 0, 32767),
                     mk_plane(0, 0, 0, 32767), mk_plane(0, 0, 0, 32767),
                     mk_plane(0, 0, 0, 32767), mk_plane(0, 0, 0, 32767));
        run_boxes(PhaseItems, 500, -1);
        settle();

        write_planes(mk_plane(-32768, 0, 0, 32767), mk_plane(32767, 0, 0, 32767),
                     mk_plane(0, 32767, 0, 32767), mk_plane(0, -32768, 0, 32767),
                     mk_plane(0, 0, -32768, 32767), mk_plane(0, 0, 32767, -32768));
        run_boxes(PhaseItems, 20000, -1);
        settle();

        write_planes(mk_plane(-32768, -32768, -32768, -32768),
                     mk_plane(32767, 32767, 32767, 32767),
                     mk_plane(32767, 32767, 32767, 32767),
                     mk_plane(-32768, -32768, -32768, -32768),
                     mk_plane(32767, 32767, 32767, 32767),
                     mk_plane(-32768, -32768, -32768, -32768));
        run_boxes(PhaseItems, 20000, -1);
        settle();

        write_planes(plane_t'({$urandom, $urandom}), plane_t'({$urandom, $urandom}),
                     plane_t'({$urandom, $urandom}), plane_t'({$urandom, $urandom}),
                     plane_t'({$urandom, $urandom}), plane_t'({$urandom, $urandom}));
        run_boxes(PhaseItems, 30000, -1);
        settle();

        write_planes(
            mk_plane(rand_between(-One, One), rand_between(-One, One),
                     rand_between(-One, One), rand_between(-2000, 2000)),
            mk_plane(rand_between(-One, One), rand_between(-One, One),
                     rand_between(-One, One), rand_between(-2000, 2000)),
            mk_plane(rand_between(-One, One), rand_between(-One, One),
                     rand_between(-One, One), rand_between(-2000, 2000)),
            mk_plane(rand_between(-One, One), rand_between(-One, One),
                     rand_between(-One, One), rand_between(-2000, 2000)),
            mk_plane(rand_between(-One, One), rand_between(-One, One),
                     rand_between(-One, One), rand_between(-2000, 2000)),
            mk_plane(rand_between(-One, One), rand_between(-One, One),
                     rand_between(-One, One), rand_between(-2000, 2000)));
        run_boxes(PhaseItems, 4000, -1);
        settle();

        $display("Classified %0d boxes under %0d plane sets plus reset planes,",
                 n_outside + n_intersect + n_inside, plane_sets);
        $display("with an output hold-off, a full drain and a gap-free stretch:");
        $display("outside %0d, intersecting %0d, inside %0d",
                 n_outside, n_intersect, n_inside);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
